[hw/rtl/ppt_pkg.sv]
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared constants and types of the projective point transform.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int unsigned COORD_FRAC = 16;
  localparam int unsigned COEF_FRAC  = 40;
  localparam int unsigned NUM_REGS   = 8;

  localparam logic [2:0] REG_COEF_XX  = 3'd0;
  localparam logic [2:0] REG_COEF_XY  = 3'd1;
  localparam logic [2:0] REG_COEF_XO  = 3'd2;
  localparam logic [2:0] REG_COEF_YX  = 3'd3;
  localparam logic [2:0] REG_COEF_YY  = 3'd4;
  localparam logic [2:0] REG_COEF_YO  = 3'd5;
  localparam logic [2:0] REG_PERSP_X  = 3'd6;
  localparam logic [2:0] REG_PERSP_Y  = 3'd7;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SAT      = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd2;

  // per-item flags carried along the divider, lane 0 is x, lane 1 is y
  typedef struct packed {
    logic       zero;
    logic [1:0] neg;
    logic [1:0] ovf;
  } div_flags_t;

endpackage

[hw/rtl/projective_point_transform.sv]
// ----------------------------------------------------------------------------
// projective_point_transform: 3x3 homography point map, Q16.16 in and out.
// One point per cycle, except while an unaccepted result stalls the whole pipe.
// The pipe has 3 multiply/sum stages, 2 sign/setup stages, one stage per quotient
// bit and the output register.
// Sync active-low reset empties the pipe and loads the identity coefficients.
// ----------------------------------------------------------------------------
module projective_point_transform import ppt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COEF_WIDTH  = 64,
  localparam int unsigned CFG_DW = (COEF_WIDTH > 32) ? 64 : 32,
  localparam int unsigned CFG_AW = (COEF_WIDTH > 32) ? 6 : 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_AW-1:0]             paddr,
  input  logic [CFG_DW-1:0]             pwdata,
  output logic [CFG_DW-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_x_in,
  input  logic signed [COORD_WIDTH-1:0] in_y_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x_out,
  output logic signed [COORD_WIDTH-1:0] out_y_out,
  output logic [1:0]                    out_status
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned SW = (COEF_WIDTH + CW + 2 > 58) ? COEF_WIDTH + CW + 2 : 58;
  localparam int unsigned NW = SW + COORD_FRAC;
  localparam logic [CW-1:0] HALF = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] MAXP = HALF - 1'b1;

  logic [NUM_REGS-1:0][COEF_WIDTH-1:0] coef;
  logic                                en;
  logic                                mac_v;
  logic signed [SW-1:0]                num_x, num_y, den;

  logic                v4_r, v5_r;
  logic [1:0][SW-1:0]  mag4_r;
  logic [SW-1:0]       d4_r, d5_r;
  div_flags_t          f4_r, f5_r, f5_nxt;
  logic [1:0][SW-1:0]  r5_r, r5_nxt;
  logic [1:0][CW-1:0]  sq5_r, sq5_nxt;

  logic                v_c  [CW+1];
  logic [SW-1:0]       d_c  [CW+1];
  logic [1:0][SW-1:0]  r_c  [CW+1];
  logic [1:0][CW-1:0]  sq_c [CW+1];
  div_flags_t          f_c  [CW+1];

  logic                  out_valid_r;
  logic [1:0][CW-1:0]    res_nxt, res_r;
  logic [1:0]            status_nxt, status_r;

  assign pready   = 1'b1;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  ppt_cfg #(.KW(COEF_WIDTH), .DW(CFG_DW), .AW(CFG_AW)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .coef
  );

  ppt_mac #(.CW(CW), .KW(COEF_WIDTH), .SW(SW)) u_mac (
    .clk, .rst_n, .en, .in_valid,
    .x(in_x_in), .y(in_y_in), .coef,
    .valid(mac_v), .num_x, .num_y, .den
  );

  // signs and magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      mag4_r[0] <= num_x[SW-1] ? SW'(~num_x + 1'b1) : SW'(num_x);
      mag4_r[1] <= num_y[SW-1] ? SW'(~num_y + 1'b1) : SW'(num_y);
      d4_r      <= den[SW-1] ? SW'(~den + 1'b1) : SW'(den);
      f4_r.zero <= den == '0;
      f4_r.neg  <= {num_y[SW-1] ^ den[SW-1], num_x[SW-1] ^ den[SW-1]};
      f4_r.ovf  <= 2'b00;
    end
  end

  // overflow check and division setup
  always_comb begin
    logic [NW-1:0] n;
    logic [SW-1:0] hi;
    f5_nxt = f4_r;
    for (int l = 0; l < 2; l++) begin
      n          = {mag4_r[l], {COORD_FRAC{1'b0}}};
      hi         = SW'(n[NW-1:CW]);
      f5_nxt.ovf[l] = hi >= d4_r;
      r5_nxt[l]  = f5_nxt.ovf[l] ? '0 : hi;
      sq5_nxt[l] = n[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d5_r  <= d4_r;
      f5_r  <= f5_nxt;
      r5_r  <= r5_nxt;
      sq5_r <= sq5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= mac_v;
      v5_r <= v4_r;
    end
  end

  assign v_c[0]  = v5_r;
  assign d_c[0]  = d5_r;
  assign r_c[0]  = r5_r;
  assign sq_c[0] = sq5_r;
  assign f_c[0]  = f5_r;

  for (genvar i = 0; i < CW; i++) begin : g_div
    ppt_div_step #(.CW(CW), .SW(SW)) u_step (
      .clk, .rst_n, .en,
      .v_in(v_c[i]), .d_in(d_c[i]), .r_in(r_c[i]), .sq_in(sq_c[i]), .flags_in(f_c[i]),
      .v_out(v_c[i+1]), .d_out(d_c[i+1]), .r_out(r_c[i+1]), .sq_out(sq_c[i+1]),
      .flags_out(f_c[i+1])
    );
  end

  // zero denominator, saturation, sign restore and status
  always_comb begin
    logic [1:0]    sat;
    logic [CW-1:0] q;
    for (int l = 0; l < 2; l++) begin
      q      = sq_c[CW][l];
      sat[l] = f_c[CW].ovf[l] || (f_c[CW].neg[l] ? (q > HALF) : (q > MAXP));
      if (f_c[CW].zero) begin
        res_nxt[l] = '0;
      end else if (sat[l]) begin
        res_nxt[l] = f_c[CW].neg[l] ? HALF : MAXP;
      end else begin
        res_nxt[l] = f_c[CW].neg[l] ? CW'(~q + 1'b1) : q;
      end
    end
    if (f_c[CW].zero) begin
      status_nxt = STATUS_ZERO_DEN;
    end else if (sat != 2'b00) begin
      status_nxt = STATUS_SAT;
    end else begin
      status_nxt = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_c[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r    <= res_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x_out  = $signed(res_r[0]);
  assign out_y_out  = $signed(res_r[1]);
  assign out_status = status_r;

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_ZERO_DEN |-> out_x_out == '0 && out_y_out == '0)
    else $error("zero denominator with nonzero result");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_SAT |->
      res_r[0] == HALF || res_r[0] == MAXP || res_r[1] == HALF || res_r[1] == MAXP)
    else $error("saturation status without a clamped coordinate");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

[hw/rtl/ppt_cfg.sv]
// ----------------------------------------------------------------------------
// ppt_cfg
// Coefficient register file behind an APB-style port.
// ----------------------------------------------------------------------------
module ppt_cfg import ppt_pkg::*; #(
  parameter int unsigned KW = 64,
  parameter int unsigned DW = 64,
  parameter int unsigned AW = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [AW-1:0]                 paddr,
  input  logic [DW-1:0]                 pwdata,
  output logic [DW-1:0]                 prdata,
  output logic [NUM_REGS-1:0][KW-1:0]   coef
);

  localparam logic [KW-1:0] ONE_VAL = KW'(64'd1 << COEF_FRAC);

  logic [NUM_REGS-1:0][KW-1:0] coef_r;
  logic [2:0]                  idx;
  logic                        wr;

  assign idx = paddr[AW-1:AW-3];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        coef_r[k] <= (k == int'(REG_COEF_XX) || k == int'(REG_COEF_YY)) ? ONE_VAL : '0;
      end
    end else if (wr) begin
      coef_r[idx] <= pwdata[KW-1:0];
    end
  end

  assign prdata = DW'($signed(coef_r[idx]));
  assign coef   = coef_r;

endmodule

[hw/rtl/ppt_mac.sv]
// ----------------------------------------------------------------------------
// ppt_mac
// Three-stage product and sum pipeline for numerators and denominator.
// ----------------------------------------------------------------------------
module ppt_mac import ppt_pkg::*; #(
  parameter int unsigned CW = 32,
  parameter int unsigned KW = 64,
  parameter int unsigned SW = 98
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [CW-1:0]        x,
  input  logic signed [CW-1:0]        y,
  input  logic [NUM_REGS-1:0][KW-1:0] coef,
  output logic                        valid,
  output logic signed [SW-1:0]        num_x,
  output logic signed [SW-1:0]        num_y,
  output logic signed [SW-1:0]        den
);

  localparam int unsigned L  = KW / 2;
  localparam int unsigned H  = KW - L;
  localparam int unsigned PW = KW + CW;
  localparam logic signed [SW-1:0] W_ONE = SW'(1) << (COEF_FRAC + COORD_FRAC);

  logic [KW-1:0]         mc [6];
  logic signed [CW-1:0]  mv [6];

  logic signed [L+CW:0]   pl_r   [6];
  logic signed [H+CW-1:0] ph_r   [6];
  logic signed [PW-1:0]   prod_r [6];
  logic signed [KW-1:0]   offx1_r, offy1_r, offx2_r, offy2_r;
  logic signed [SW-1:0]   num_x_r, num_y_r, den_r;
  logic                   v1_r, v2_r, v3_r;

  assign mc[0] = coef[REG_COEF_XX];  assign mv[0] = x;
  assign mc[1] = coef[REG_COEF_XY];  assign mv[1] = y;
  assign mc[2] = coef[REG_COEF_YX];  assign mv[2] = x;
  assign mc[3] = coef[REG_COEF_YY];  assign mv[3] = y;
  assign mc[4] = coef[REG_PERSP_X];  assign mv[4] = x;
  assign mc[5] = coef[REG_PERSP_Y];  assign mv[5] = y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        pl_r[k]   <= $signed({1'b0, mc[k][L-1:0]}) * mv[k];
        ph_r[k]   <= $signed(mc[k][KW-1:L]) * mv[k];
        prod_r[k] <= (PW'(ph_r[k]) <<< L) + PW'(pl_r[k]);
      end
      offx1_r <= $signed(coef[REG_COEF_XO]);
      offy1_r <= $signed(coef[REG_COEF_YO]);
      offx2_r <= offx1_r;
      offy2_r <= offy1_r;
      num_x_r <= SW'(prod_r[0]) + SW'(prod_r[1]) + (SW'(offx2_r) <<< COORD_FRAC);
      num_y_r <= SW'(prod_r[2]) + SW'(prod_r[3]) + (SW'(offy2_r) <<< COORD_FRAC);
      den_r   <= W_ONE + SW'(prod_r[4]) + SW'(prod_r[5]);
    end
  end

  assign valid = v3_r;
  assign num_x = num_x_r;
  assign num_y = num_y_r;
  assign den   = den_r;

endmodule

[hw/rtl/ppt_div_step.sv]
// ----------------------------------------------------------------------------
// ppt_div_step
// One restoring-division step for both lanes: one quotient bit per stage.
// ----------------------------------------------------------------------------
module ppt_div_step import ppt_pkg::*; #(
  parameter int unsigned CW = 32,
  parameter int unsigned SW = 98
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  v_in,
  input  logic [SW-1:0]         d_in,
  input  logic [1:0][SW-1:0]    r_in,
  input  logic [1:0][CW-1:0]    sq_in,
  input  div_flags_t            flags_in,
  output logic                  v_out,
  output logic [SW-1:0]         d_out,
  output logic [1:0][SW-1:0]    r_out,
  output logic [1:0][CW-1:0]    sq_out,
  output div_flags_t            flags_out
);

  logic                   v_r;
  logic [SW-1:0]          d_r;
  logic [1:0][SW-1:0]     r_r, r_nxt;
  logic [1:0][CW-1:0]     sq_r, sq_nxt;
  div_flags_t             flags_r;

  // sq holds the unconsumed dividend bits on top, quotient bits enter at the bottom
  always_comb begin
    logic [SW:0] t;
    logic [SW:0] diff;
    logic        ge;
    for (int l = 0; l < 2; l++) begin
      t         = {r_in[l], sq_in[l][CW-1]};
      diff      = t - {1'b0, d_in};
      ge        = t >= {1'b0, d_in};
      r_nxt[l]  = ge ? diff[SW-1:0] : t[SW-1:0];
      sq_nxt[l] = {sq_in[l][CW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r     <= d_in;
      r_r     <= r_nxt;
      sq_r    <= sq_nxt;
      flags_r <= flags_in;
    end
  end

  assign v_out     = v_r;
  assign d_out     = d_r;
  assign r_out     = r_r;
  assign sq_out    = sq_r;
  assign flags_out = flags_r;

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: projective_point_transform testbench
// Loads several coefficient sets over the register port (identity, affine,
// perspective, all extremes) and streams points through the block with random
// idling on both sides. A scoreboard predicts each point with exact 128-bit products
// and a 144-bit division, and compares x, y and status of every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ppt_pkg::*;

  localparam int CW = 32;
  localparam int LAT = CW + 6;

  class point_scoreboard;
    logic signed [63:0] coef [8];
    logic [31:0] exp_x [$];
    logic [31:0] exp_y [$];
    logic [1:0]  exp_st [$];
    int errors;

    function new();
      errors = 0;
      load_identity();
    endfunction

    function void load_identity();
      foreach (coef[i]) coef[i] = '0;
      coef[REG_COEF_XX] = 64'sd1 <<< COEF_FRAC;
      coef[REG_COEF_YY] = 64'sd1 <<< COEF_FRAC;
    endfunction

    function void add_expect(logic [31:0] x, logic [31:0] y, logic [1:0] st);
      exp_x = {exp_x, x};
      exp_y = {exp_y, y};
      exp_st = {exp_st, st};
    endfunction

    function logic [31:0] quotient(logic signed [127:0] num, logic signed [127:0] den,
                                   inout bit sat);
      logic [143:0] n, d, q;
      bit neg;
      logic [143:0] lim;
      neg = num[127] ^ den[127];
      n = num[127] ? {16'd0, -num} : {16'd0, num};
      d = den[127] ? {16'd0, -den} : {16'd0, den};
      q = (n << COORD_FRAC) / d;
      lim = neg ? (144'd1 << (CW - 1)) : ((144'd1 << (CW - 1)) - 1);
      if (q > lim) begin
        sat = 1;
        q = lim;
      end
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function void note_point(logic signed [31:0] x, logic signed [31:0] y);
      logic signed [127:0] w, nx, ny, xs, ys, one;
      logic [31:0] ex, ey;
      bit sat;
      xs = x;
      ys = y;
      one = 128'sd1 << COORD_FRAC;
      sat = 0;
      w = (128'sd1 <<< (COEF_FRAC + COORD_FRAC)) + 128'(coef[REG_PERSP_X]) * xs
          + 128'(coef[REG_PERSP_Y]) * ys;
      if (w == 0) begin
        add_expect('0, '0, STATUS_ZERO_DEN);
        return;
      end
      nx = 128'(coef[REG_COEF_XX]) * xs + 128'(coef[REG_COEF_XY]) * ys
           + 128'(coef[REG_COEF_XO]) * one;
      ny = 128'(coef[REG_COEF_YX]) * xs + 128'(coef[REG_COEF_YY]) * ys
           + 128'(coef[REG_COEF_YO]) * one;
      ex = quotient(nx, w, sat);
      ey = quotient(ny, w, sat);
      add_expect(ex, ey, sat ? STATUS_SAT : STATUS_OK);
    endfunction

    function void check_point(logic [31:0] x, logic [31:0] y, logic [1:0] st);
      logic [31:0] ex, ey;
      logic [1:0] es;
      if (exp_x.size() == 0) begin
        $display("%0t unexpected result x=%h y=%h status=%0d", $time, x, y, st);
        errors++;
        return;
      end
      ex = exp_x.pop_front();
      ey = exp_y.pop_front();
      es = exp_st.pop_front();
      if (x !== ex) begin
        $display("%0t x_out mismatch: expected %h actual %h", $time, ex, x);
        errors++;
      end
      if (y !== ey) begin
        $display("%0t y_out mismatch: expected %h actual %h", $time, ey, y);
        errors++;
      end
      if (st !== es) begin
        $display("%0t status mismatch: expected %0d actual %0d", $time, es, st);
        errors++;
      end
    endfunction

    function int pending();
      return exp_x.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] in_x = '0, in_y = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_x, out_y;
  logic [1:0] out_st;

  int send_idle = 10;
  int recv_idle = 64;
  bit hold_off = 0;

  point_scoreboard sb = new();

  projective_point_transform uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_x_in(in_x), .in_y_in(in_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_x_out(out_x),
    .out_y_out(out_y), .out_status(out_st)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_point(out_x, out_y, out_st);
    if (rst_n && in_valid && in_ready) sb.note_point(in_x, in_y);
  end

  always @(posedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    psel <= 1;
    pwrite <= 1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.coef[idx] = val;
    @(posedge clk);
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_x <= x;
    in_y <= y;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(2047) - 1024;
      3: return $signed($urandom_range(65535)) <<< $urandom_range(16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_coef();
    case ($urandom_range(6))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '0;
      3: return 64'($signed($urandom_range(8191) - 4096)) <<< 28;
      4: return 64'($signed($urandom)) <<< $urandom_range(24);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_points(int count);
    repeat (count) send_point(rand_coord(), rand_coord());
  endtask

  logic [63:0] one_c;

  initial begin
    one_c = 64'd1 << COEF_FRAC;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // identity after reset: coordinate extremes
    send_point(32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    send_point(0, 0);
    send_point(32'hffff_ffff, 32'h0001_0000);
    drain();

    // saturation: scale x by 4 and y by the most negative coefficient
    write_reg(REG_COEF_XX, one_c << 2);
    write_reg(REG_COEF_YY, 64'h8000_0000_0000_0000);
    send_point(32'h7fff_ffff, 32'h0000_0001);
    send_point(32'h4000_0000, 32'hffff_0000);
    send_point(32'h0000_1000, 32'h8000_0000);

    // zero and negative denominators
    drain();
    write_reg(REG_COEF_XX, one_c);
    write_reg(REG_COEF_YY, one_c);
    write_reg(REG_COEF_XO, 64'h7fff_ffff_ffff_ffff);
    write_reg(REG_COEF_YO, 64'hffff_ff00_0000_0000);
    write_reg(REG_PERSP_X, -(one_c >> 4));
    write_reg(REG_PERSP_Y, '0);
    send_point(32'h0010_0000, 32'h1234_5678);
    send_point(32'h0020_0000, 32'h0001_0000);
    send_point(32'h0008_0000, 32'hffff_8000);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    drain();
    write_reg(REG_PERSP_Y, one_c >> 8);
    write_reg(REG_COEF_XY, 64'h8000_0000_0000_0000);
    write_reg(REG_COEF_YX, one_c >> 1);
    send_point(32'h0010_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'hff00_0000);
    send_point(32'h0001_0000, 32'h0001_0000);
    drain();

    // random phases with fresh coefficients
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle = 64;
        recv_idle = 10;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (ph == 0) sb.load_identity();
      for (int r = 0; r < 8; r++) begin
        if (ph == 0) write_reg(r[2:0], sb.coef[r]);
        else if (r >= 6 && $urandom_range(2) == 0) write_reg(r[2:0], '0);
        else write_reg(r[2:0], rand_coef());
      end
      if (ph == 3) begin
        fork
          begin
            hold_off = 1;
            repeat (200) @(posedge clk);
            hold_off = 0;
          end
          random_points(75);
        join
      end else begin
        random_points(75);
      end
      drain();
    end

    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end
endmodule
